[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// No dependencies; include this header by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge while reset is released.
`define TMHC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("tmhc assertion failed");

// Expression must never be true at a rising edge while reset is released.
`define TMHC_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("tmhc forbidden condition seen");

`endif

[rtl/tmhc_pkg.sv]
// Shared types and constants of the tolerance map hit counter.
// No dependencies; used by the top level and the checker.
package tmhc_pkg;

    localparam int COORD_W = 16;
    localparam int TOL_W   = 12;
    localparam int COUNT_W = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_MARK  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Register index taken from the word address paddr[2].
    localparam logic REG_TOLERANCE = 1'b0;

    localparam logic [TOL_W-1:0] TOL_RESET = 12'd16;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [COORD_W-1:0] u_coord;
        logic signed [COORD_W-1:0] v_coord;
        logic                      last_query;
    } cmd_t;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] hit_count;
        logic               batch_done;
    } res_t;

endpackage

[rtl/tmhc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tmhc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tolerance_map_hit_counter.sv]
// Top level of the tolerance map hit counter: sequencer, map RAM and APB register.
// Depends on tmhc_pkg and tmhc_ram.
//
//   channel   direction  handshake                   beat
//   --------  ---------  --------------------------  --------------------------
//   command   in         start & !busy               cmd (command, u, v, last)
//   result    out        done, one cycle, no stall   result (hit, count, done)
//   config    in         APB psel/penable/pwrite     tolerance at paddr 0
//
// A query beat runs through accept, map word read and result register. A mark
// beat runs a setup step, then a read and a merge-write for every map word it
// touches; the map RAM has a single port pair. A clear beat sweeps all the
// GRID_DIM*GRID_DIM/WORD_W map words (4096 at the default size), one word a
// cycle. After reset the same sweep runs before the first beat is taken; APB
// writes are accepted throughout. The receiver cannot stall: each result beat
// is shown on done for exactly one cycle.
module tolerance_map_hit_counter
    import tmhc_pkg::*;
#(
    parameter int GRID_DIM  = 512,
    parameter int FRAC_BITS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  cmd_t               cmd,
    output logic               done,
    output res_t               result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // The map is stored row by row in words of WORD_W cells. GRID_DIM is a
    // power of two, so a row always holds at least two words.
    localparam int IDX_W   = $clog2(GRID_DIM);
    localparam int WORD_W  = (GRID_DIM >= 128) ? 64 : (GRID_DIM / 2);
    localparam int LOG_W   = $clog2(WORD_W);
    localparam int WIDX_W  = IDX_W - LOG_W;
    localparam int ADDR_W  = IDX_W + WIDX_W;
    localparam int DEPTH   = GRID_DIM * (GRID_DIM / WORD_W);
    localparam int EXT_A   = IDX_W + FRAC_BITS + 2;
    localparam int EXT_W   = (EXT_A > 18) ? EXT_A : 18;
    localparam int EDGE_I  = GRID_DIM * (2 ** FRAC_BITS);
    localparam int LAST_I  = (GRID_DIM - 1) * (2 ** FRAC_BITS);
    localparam int HALF_I  = (FRAC_BITS == 0) ? 0 : (2 ** (FRAC_BITS - 1));

    localparam logic signed [EXT_W-1:0] EDGE_FX  = EXT_W'(EDGE_I);
    localparam logic signed [EXT_W-1:0] LAST_FX  = EXT_W'(LAST_I);
    localparam logic signed [EXT_W-1:0] HALF_FX  = EXT_W'(HALF_I);
    localparam logic signed [EXT_W-1:0] SIZE_EXT = EXT_W'(GRID_DIM);
    localparam logic signed [EXT_W-1:0] ZERO_EXT = '0;

    // One-hot state codes of the sequencer.
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CLEAR  = 7'b0000010,
        ST_MSETUP = 7'b0000100,
        ST_MREAD  = 7'b0001000,
        ST_MWRITE = 7'b0010000,
        ST_QREAD  = 7'b0100000,
        ST_QOUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    cmd_t               cmd_reg, cmd_next;
    logic [TOL_W-1:0]   tol_reg;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [IDX_W-1:0]   last_row_reg, last_row_next;
    logic [WIDX_W-1:0]  word_reg, word_next;
    logic [IDX_W-1:0]   first_col_reg, first_col_next;
    logic [IDX_W-1:0]   last_col_reg, last_col_next;
    logic               qok_reg, qok_next;
    logic [LOG_W-1:0]   qbit_reg, qbit_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               done_reg, done_next;
    res_t               result_reg, result_next;

    // Map RAM ports.
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    // Fixed-point views of the held command coordinates.
    logic signed [EXT_W-1:0] u_ext, v_ext, tol_ext;
    logic signed [EXT_W-1:0] ulo_fx, uhi_fx, vlo_fx, vhi_fx;
    logic signed [EXT_W-1:0] uhi_clip, vhi_clip, last_col_fx, last_row_fx;
    logic signed [EXT_W-1:0] qcol_fx, qrow_fx;
    logic                    mark_ok, query_ok;

    // Shared merge unit for mark writes.
    logic [LOG_W-1:0]   lo_off, hi_bit;
    logic [WORD_W-1:0]  merge_mask;
    logic               word_is_last, row_is_last;

    logic               hit_now;
    logic [COUNT_W-1:0] count_inc;
    logic               cfg_write;

    tmhc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // APB register. Writes are taken in the access phase; pready is tied high.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_TOLERANCE)
                       ? {{(PDATA_W - TOL_W){1'b0}}, tol_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_TOLERANCE))
        begin
            tol_reg <= pwdata[TOL_W-1:0];
        end
    end

    // Coordinate arithmetic. Every operand is widened so that no sum can wrap.
    assign u_ext   = {{(EXT_W - COORD_W){cmd_reg.u_coord[COORD_W-1]}}, cmd_reg.u_coord};
    assign v_ext   = {{(EXT_W - COORD_W){cmd_reg.v_coord[COORD_W-1]}}, cmd_reg.v_coord};
    assign tol_ext = {{(EXT_W - TOL_W){1'b0}}, tol_reg};

    // The mark bounds are only used once the point passed the edge check, so
    // the arithmetic shift is a floor of a non-negative value.
    assign ulo_fx  = (u_ext - tol_ext) >>> FRAC_BITS;
    assign uhi_fx  = (u_ext + tol_ext) >>> FRAC_BITS;
    assign vlo_fx  = (v_ext - tol_ext) >>> FRAC_BITS;
    assign vhi_fx  = (v_ext + tol_ext) >>> FRAC_BITS;
    assign uhi_clip    = (uhi_fx > SIZE_EXT) ? SIZE_EXT : uhi_fx;
    assign vhi_clip    = (vhi_fx > SIZE_EXT) ? SIZE_EXT : vhi_fx;
    assign last_col_fx = uhi_clip - EXT_W'(1);
    assign last_row_fx = vhi_clip - EXT_W'(1);

    // A point too close to an edge marks nothing, and so does a square whose
    // bounds round to an empty range (a zero tolerance among others).
    assign mark_ok = !(u_ext < tol_ext) && !(v_ext < tol_ext)
                     && !(u_ext > (EDGE_FX - tol_ext)) && !(v_ext > (EDGE_FX - tol_ext))
                     && (uhi_clip > ulo_fx) && (vhi_clip > vlo_fx);

    // Query rounding: add one half cell, then floor.
    assign qcol_fx  = (u_ext + HALF_FX) >>> FRAC_BITS;
    assign qrow_fx  = (v_ext + HALF_FX) >>> FRAC_BITS;
    assign query_ok = !(u_ext < ZERO_EXT) && !(v_ext < ZERO_EXT)
                      && !(u_ext > LAST_FX) && !(v_ext > LAST_FX)
                      && (qcol_fx < SIZE_EXT) && (qrow_fx < SIZE_EXT);

    // Merge mask of the current word: cells from the first to the last marked
    // column that fall inside this word.
    assign word_is_last = (word_reg == last_col_reg[IDX_W-1:LOG_W]);
    assign row_is_last  = (row_reg == last_row_reg);
    assign lo_off     = (word_reg == first_col_reg[IDX_W-1:LOG_W])
                        ? first_col_reg[LOG_W-1:0] : '0;
    assign hi_bit     = word_is_last ? last_col_reg[LOG_W-1:0] : '1;
    assign merge_mask = ({WORD_W{1'b1}} << lo_off) & ({WORD_W{1'b1}} >> (~hi_bit));

    // RAM port steering.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {row_reg, word_reg};
        ram_wdata = ram_rdata | merge_mask;
        if (state_reg == ST_QREAD)
        begin
            ram_raddr = {qrow_fx[IDX_W-1:0], qcol_fx[IDX_W-1:LOG_W]};
        end
        else
        begin
            ram_raddr = {row_reg, word_reg};
        end
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == ST_MWRITE)
        begin
            ram_we = 1'b1;
        end
    end

    // Saturating hit counter update of the query now being finished.
    assign hit_now   = qok_reg && ram_rdata[qbit_reg];
    assign count_inc = (hit_now && (count_reg != '1)) ? (count_reg + COUNT_W'(1)) : count_reg;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        clr_addr_next  = clr_addr_reg;
        row_next       = row_reg;
        last_row_next  = last_row_reg;
        word_next      = word_reg;
        first_col_next = first_col_reg;
        last_col_next  = last_col_reg;
        qok_next       = qok_reg;
        qbit_next      = qbit_reg;
        count_next     = count_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    case (cmd.command)
                        CMD_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        CMD_MARK:
                        begin
                            state_next = ST_MSETUP;
                        end
                        CMD_QUERY:
                        begin
                            state_next = ST_QREAD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MSETUP:
            begin
                first_col_next = ulo_fx[IDX_W-1:0];
                last_col_next  = last_col_fx[IDX_W-1:0];
                row_next       = vlo_fx[IDX_W-1:0];
                last_row_next  = last_row_fx[IDX_W-1:0];
                word_next      = ulo_fx[IDX_W-1:LOG_W];
                state_next     = mark_ok ? ST_MREAD : ST_IDLE;
            end
            ST_MREAD:
            begin
                state_next = ST_MWRITE;
            end
            ST_MWRITE:
            begin
                if (!word_is_last)
                begin
                    word_next  = word_reg + WIDX_W'(1);
                    state_next = ST_MREAD;
                end
                else if (!row_is_last)
                begin
                    row_next   = row_reg + IDX_W'(1);
                    word_next  = first_col_reg[IDX_W-1:LOG_W];
                    state_next = ST_MREAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QREAD:
            begin
                qok_next   = query_ok;
                qbit_next  = qcol_fx[LOG_W-1:0];
                state_next = ST_QOUT;
            end
            ST_QOUT:
            begin
                result_next.hit        = hit_now;
                result_next.hit_count  = count_inc;
                result_next.batch_done = cmd_reg.last_query;
                done_next              = 1'b1;
                count_next             = cmd_reg.last_query ? '0 : count_inc;
                state_next             = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state. Reset starts the clearing pass over the whole map.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
        end
    end

    // Payload and loop registers need no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        row_reg       <= row_next;
        last_row_reg  <= last_row_next;
        word_reg      <= word_next;
        first_col_reg <= first_col_next;
        last_col_reg  <= last_col_next;
        qok_reg       <= qok_next;
        qbit_reg      <= qbit_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/tmhc_checker.sv]
// Port-level checker of the tolerance map hit counter, bound to the top level.
// Depends on tmhc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tmhc_checker
    import tmhc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input cmd_t cmd,
    input logic done,
    input res_t result
);

    logic query_taken;

    assign query_taken = start && !busy && (cmd.command == CMD_QUERY);

    // Every accepted query is answered once its map word is read and its result registered.
    `TMHC_ASSERT(a_query_answered, clk, rst_n, query_taken |-> ##3 done)

    // Results never come on back-to-back cycles.
    `TMHC_ASSERT(a_done_single, clk, rst_n, done |=> !done)

    // A result beat only appears once the sequencer is back in idle.
    `TMHC_NEVER(a_done_while_busy, clk, rst_n, done && busy)

    // A hit always leaves a nonzero count in the same beat.
    `TMHC_NEVER(a_hit_count_zero, clk, rst_n,
        done && result.hit && (result.hit_count == '0))

endmodule

bind tolerance_map_hit_counter tmhc_checker u_tmhc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);

[tb/tb_tolerance_map_hit_counter.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the tolerance map hit counter: directed beats, then random
// phases at several tolerances and sender idle rates.
// Depends on tmhc_pkg and tolerance_map_hit_counter from the rtl folder.
module tb_tolerance_map_hit_counter;
    import tmhc_pkg::*;

    // Geometry of the map in cells and in fixed point. The block is built with the same
    // values, so the predictor below walks exactly the cells the RAM holds.
    localparam int MAP_N   = 512;
    localparam int FRAC    = 4;
    localparam int ONE_FX  = 1 << FRAC;
    localparam int HALF_FX = ONE_FX >> 1;
    localparam int EDGE_FX = MAP_N * ONE_FX;
    localparam int LAST_FX = (MAP_N - 1) * ONE_FX;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    // Command code the block must ignore without a result.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] TOL_ADDR = {REG_TOLERANCE, 2'b00};

    localparam int CLK_PERIOD = 2;
    // A mark at the widest tolerance reads and rewrites 512 rows of 8 map words each,
    // and a clear sweeps 4096 words. Commands without a result may still be running when
    // the last query result has come, so configuration writes and the end of the run wait
    // this long after the expectation queue has drained.
    localparam int SETTLE_CYCLES = 8400;
    // Several times the slowest legal run, which is dominated by the clears, the widest
    // marks and the settle pauses.
    localparam int CYCLE_LIMIT = 3_000_000;

    // One row of the directed table: either a tolerance write or a command beat. Rows that
    // carry a typed result push it instead of the predicted one.
    typedef struct packed {
        bit               set_tol;
        logic [TOL_W-1:0] tol;
        cmd_t             beat;
        bit               typed;
        res_t             typed_res;
    } directed_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    cmd_t               cmd = '0;
    logic               done;
    res_t               result;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Predictor state: its own copy of the map, the batch counter and the tolerance.
    bit [MAP_N-1:0]   occ_rows [MAP_N];
    logic [COUNT_W-1:0] batch_hits = '0;
    logic [TOL_W-1:0] tolerance_reg = TOL_RESET;

    // Results of accepted query beats that have not come out of the block yet.
    res_t query_results_due [$];
    directed_row_t directed_rows [$];

    int sender_idle_pct = 0;
    int items_sent = 0;
    int marks_sent = 0;
    int clears_sent = 0;
    int queries_sent = 0;
    int results_checked = 0;
    int hits_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;

    tolerance_map_hit_counter #(
        .GRID_DIM  (MAP_N),
        .FRAC_BITS (FRAC)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Counts every mismatch; only the first few are printed so a broken block does not
    // flood the log.
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
        end
    endtask

    // Applies one accepted beat to the predictor state. A query yields one result; clear,
    // mark and the unused code change state at most and yield nothing.
    function automatic void predict_query_result(input cmd_t c, output bit produces,
                                                 output res_t r);
        int u;
        int v;
        int tol;
        int ulo;
        int uhi;
        int vlo;
        int vhi;
        int col;
        int row;
        bit hit;
        u = $signed(c.u_coord);
        v = $signed(c.v_coord);
        tol = tolerance_reg;
        hit = 1'b0;
        produces = 1'b0;
        r = '0;
        case (c.command)
            CMD_CLEAR:
            begin
                foreach (occ_rows[i])
                begin
                    occ_rows[i] = '0;
                end
            end
            CMD_MARK:
            begin
                // Points closer to an edge than the tolerance leave the map alone. All
                // operands are non-negative here, so the shifts round toward minus infinity.
                if (u >= tol && v >= tol && u <= EDGE_FX - tol && v <= EDGE_FX - tol)
                begin
                    ulo = (u - tol) >> FRAC;
                    uhi = (u + tol) >> FRAC;
                    vlo = (v - tol) >> FRAC;
                    vhi = (v + tol) >> FRAC;
                    if (uhi > MAP_N)
                    begin
                        uhi = MAP_N;
                    end
                    if (vhi > MAP_N)
                    begin
                        vhi = MAP_N;
                    end
                    for (row = vlo; row < vhi; row++)
                    begin
                        for (col = ulo; col < uhi; col++)
                        begin
                            occ_rows[row][col] = 1'b1;
                        end
                    end
                end
            end
            CMD_QUERY:
            begin
                // In-range points round half up to a cell; the rounded cell of the top
                // in-range coordinate is still the last row or column.
                if (u >= 0 && v >= 0 && u <= LAST_FX && v <= LAST_FX)
                begin
                    col = (u + HALF_FX) >> FRAC;
                    row = (v + HALF_FX) >> FRAC;
                    hit = occ_rows[row][col];
                end
                if (hit && batch_hits != COUNT_MAX)
                begin
                    batch_hits++;
                end
                r.hit = hit;
                r.hit_count = batch_hits;
                r.batch_done = c.last_query;
                if (c.last_query)
                begin
                    batch_hits = '0;
                end
                produces = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic cmd_t make_beat(input logic [1:0] command, input int u, input int v,
                                       input bit last);
        cmd_t c;
        c.command = command;
        c.u_coord = 16'(u);
        c.v_coord = 16'(v);
        c.last_query = last;
        return c;
    endfunction

    function automatic directed_row_t beat_row(input logic [1:0] command, input int u,
                                               input int v, input bit last);
        directed_row_t row;
        row = '0;
        row.beat = make_beat(command, u, v, last);
        return row;
    endfunction

    // A query row whose result is obvious at a glance; batch_done always echoes last.
    function automatic directed_row_t typed_query(input int u, input int v, input bit last,
                                                  input bit hit, input int count);
        directed_row_t row;
        row = beat_row(CMD_QUERY, u, v, last);
        row.typed = 1'b1;
        row.typed_res.hit = hit;
        row.typed_res.hit_count = COUNT_W'(count);
        row.typed_res.batch_done = last;
        return row;
    endfunction

    function automatic directed_row_t tol_row(input int t);
        directed_row_t row;
        row = '0;
        row.set_tol = 1'b1;
        row.tol = TOL_W'(t);
        return row;
    endfunction

    // Presents one beat and holds it until the block takes it. Start is left high on
    // return, so a following beat goes out back to back; idle cycles are inserted at random
    // before the beat according to the current phase.
    task automatic send_beat(input cmd_t c, input bit typed, input res_t typed_res);
        bit   produces;
        res_t r;
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        predict_query_result(c, produces, r);
        if (produces)
        begin
            query_results_due.push_back(typed ? typed_res : r);
        end
        case (c.command)
            CMD_CLEAR: clears_sent++;
            CMD_MARK:  marks_sent++;
            CMD_QUERY: queries_sent++;
            default:   ;
        endcase
        if (c.command != CMD_UNUSED)
        begin
            items_sent++;
        end
    endtask

    // Stops sending, lets every expected result arrive, then gives any clear or mark still
    // in flight time to finish.
    task automatic wait_block_idle();
        start <= 1'b0;
        while (query_results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB transfer to the tolerance register: a setup phase, then the access phase
    // that completes on pready. The bus is left selected so that a second transfer can
    // follow directly; the caller releases it.
    task automatic apb_xfer(input bit is_write, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= TOL_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        rdata = prdata;
    endtask

    // Writes the tolerance with random bits above the register width, which the block must
    // drop, and reads it back.
    task automatic set_tolerance(input logic [TOL_W-1:0] t);
        logic [PDATA_W-1:0] wdata;
        logic [PDATA_W-1:0] rdata;
        wait_block_idle();
        wdata = $urandom;
        wdata[TOL_W-1:0] = t;
        apb_xfer(1'b1, wdata, rdata);
        apb_xfer(1'b0, '0, rdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tolerance_reg = t;
        if (rdata[TOL_W-1:0] !== t)
        begin
            report_mismatch("tolerance read back", 32'(t), 32'(rdata[TOL_W-1:0]));
        end
    endtask

    // Mark coordinates sit mostly inside the legal band, sometimes exactly on its edges and
    // sometimes one step outside, where the mark must be skipped.
    function automatic int pick_mark_coord(input int lo, input int hi);
        case ($urandom_range(15, 0))
            0:       return lo;
            1:       return hi;
            2:       return lo - 1;
            3:       return hi + 1;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // A well-formed batch: a few reference points, then queries clustered around them so
    // that hits are common, closed by a last query most of the time. A few queries land
    // anywhere around the map, including just outside it.
    task automatic send_batch();
        int   n_marks;
        int   n_queries;
        int   k;
        int   j;
        int   lo;
        int   hi;
        int   span;
        int   cu [3];
        int   cv [3];
        bit   last;
        cmd_t c;
        lo = tolerance_reg;
        hi = EDGE_FX - tolerance_reg;
        span = tolerance_reg + 40;
        n_marks = $urandom_range(3, 1);
        for (k = 0; k < n_marks; k++)
        begin
            cu[k] = pick_mark_coord(lo, hi);
            cv[k] = pick_mark_coord(lo, hi);
            // Last is meaningless on a mark and is sent at random.
            send_beat(make_beat(CMD_MARK, cu[k], cv[k], 1'($urandom_range(1, 0))), 1'b0, '0);
        end
        n_queries = $urandom_range(8, 1);
        for (k = 0; k < n_queries; k++)
        begin
            last = (k == n_queries - 1) && ($urandom_range(5, 0) != 0);
            if ($urandom_range(7, 0) == 0)
            begin
                c = make_beat(CMD_QUERY, int'($urandom_range(LAST_FX + 48, 0)) - 24,
                              int'($urandom_range(LAST_FX + 48, 0)) - 24, last);
            end
            else
            begin
                j = $urandom_range(n_marks - 1, 0);
                c = make_beat(CMD_QUERY, cu[j] + int'($urandom_range(2 * span, 0)) - span,
                              cv[j] + int'($urandom_range(2 * span, 0)) - span, last);
            end
            send_beat(c, 1'b0, '0);
        end
    endtask

    // One random phase at a fixed tolerance and sender idle rate. Halfway through, the
    // sender holds off until every outstanding result has come back.
    task automatic run_random_phase(input logic [TOL_W-1:0] t, input int idle_pct,
                                    input int n);
        int stop_at;
        int pause_at;
        int pick;
        int k;
        bit paused;
        set_tolerance(t);
        sender_idle_pct = idle_pct;
        stop_at = items_sent + n;
        pause_at = items_sent + n / 2;
        paused = 1'b0;
        while (items_sent < stop_at)
        begin
            if (!paused && items_sent >= pause_at)
            begin
                paused = 1'b1;
                if (query_results_due.size() != 0)
                begin
                    start <= 1'b0;
                    while (query_results_due.size() != 0)
                    begin
                        @(posedge clk);
                    end
                end
            end
            pick = $urandom_range(99, 0);
            if (pick < 4)
            begin
                // A clear sweeps the whole map, so it stays rare; its payload is junk.
                send_beat(make_beat(CMD_CLEAR, $urandom, $urandom, 1'($urandom_range(1, 0))),
                          1'b0, '0);
            end
            else if (pick < 16)
            begin
                // Noise: any command code with every coordinate bit random.
                for (k = 0; k < $urandom_range(3, 1); k++)
                begin
                    send_beat(make_beat(2'($urandom), $urandom, $urandom,
                                        1'($urandom_range(1, 0))), 1'b0, '0);
                end
            end
            else
            begin
                send_batch();
            end
        end
    endtask

    // Result checker. The block cannot be stalled, so every strobed beat is taken at the
    // edge that ends its cycle and compared with the oldest expectation.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done !== 1'b0)
        begin
            if (query_results_due.size() == 0)
            begin
                report_mismatch("result with nothing pending", '0, 32'(result));
            end
            else
            begin
                want = query_results_due.pop_front();
                results_checked++;
                if (result.hit === 1'b1)
                begin
                    hits_seen++;
                end
                if (result.hit !== want.hit)
                begin
                    report_mismatch("hit", 32'(want.hit), 32'(result.hit));
                end
                if (result.hit_count !== want.hit_count)
                begin
                    report_mismatch("hit_count", 32'(want.hit_count), 32'(result.hit_count));
                end
                if (result.batch_done !== want.batch_done)
                begin
                    report_mismatch("batch_done", 32'(want.batch_done),
                                    32'(result.batch_done));
                end
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, query_results_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        logic [PDATA_W-1:0] rdata;

        foreach (occ_rows[i])
        begin
            occ_rows[i] = '0;
        end

        // Directed rows at the reset tolerance of one cell unless a row changes it.
        // Right after reset the map is empty, so the first queries all miss; they probe the
        // coordinate extremes and both sides of the upper range limit.
        directed_rows.push_back(typed_query(0, 0, 1'b0, 1'b0, 0));
        directed_rows.push_back(typed_query(-32768, -32768, 1'b0, 1'b0, 0));
        directed_rows.push_back(typed_query(32767, 32767, 1'b0, 1'b0, 0));
        directed_rows.push_back(typed_query(LAST_FX, LAST_FX, 1'b0, 1'b0, 0));
        directed_rows.push_back(typed_query(LAST_FX + 1, 0, 1'b0, 1'b0, 0));
        // Mark exactly on the lower edge band, then hit it, including rounding half up
        // onto the marked cell and just past it.
        directed_rows.push_back(beat_row(CMD_MARK, ONE_FX, ONE_FX, 1'b0));
        directed_rows.push_back(beat_row(CMD_QUERY, 0, 0, 1'b0));
        directed_rows.push_back(beat_row(CMD_QUERY, 23, 23, 1'b0));
        directed_rows.push_back(beat_row(CMD_QUERY, 24, 0, 1'b0));
        // Marks one step inside each edge band are skipped; on the upper edge it is taken.
        directed_rows.push_back(beat_row(CMD_MARK, ONE_FX - 1, 100, 1'b0));
        directed_rows.push_back(beat_row(CMD_MARK, EDGE_FX - ONE_FX, EDGE_FX - ONE_FX, 1'b0));
        directed_rows.push_back(beat_row(CMD_MARK, EDGE_FX - ONE_FX + 1, 100, 1'b0));
        // Top corner hit closes the batch; the next query starts a new count.
        directed_rows.push_back(beat_row(CMD_QUERY, LAST_FX, LAST_FX, 1'b1));
        directed_rows.push_back(beat_row(CMD_QUERY, 0, 0, 1'b0));
        // The unused code and a clear give no result; a clear keeps the count.
        directed_rows.push_back(beat_row(CMD_UNUSED, 0, 0, 1'b1));
        directed_rows.push_back(beat_row(CMD_CLEAR, -1, 12345, 1'b1));
        directed_rows.push_back(beat_row(CMD_QUERY, 0, 0, 1'b1));
        // Zero tolerance marks nothing.
        directed_rows.push_back(tol_row(0));
        directed_rows.push_back(beat_row(CMD_MARK, 4096, 4096, 1'b1));
        directed_rows.push_back(beat_row(CMD_QUERY, 4096, 4096, 1'b0));
        // Widest tolerance: only points at the centre pass, and the square then covers
        // every cell but the last row and column. A negative coordinate ends the batch.
        directed_rows.push_back(tol_row((1 << TOL_W) - 1));
        directed_rows.push_back(beat_row(CMD_MARK, 4096, 4096, 1'b0));
        directed_rows.push_back(beat_row(CMD_QUERY, 0, 0, 1'b0));
        directed_rows.push_back(beat_row(CMD_QUERY, LAST_FX, LAST_FX, 1'b0));
        directed_rows.push_back(beat_row(CMD_QUERY, -1, 0, 1'b1));
        directed_rows.push_back(beat_row(CMD_CLEAR, 0, 0, 1'b0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The register must come out of reset at one cell. The block may still be sweeping
        // its map; the register port is served meanwhile.
        apb_xfer(1'b0, '0, rdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rdata[TOL_W-1:0] !== TOL_RESET)
        begin
            report_mismatch("tolerance after reset", 32'(TOL_RESET), 32'(rdata[TOL_W-1:0]));
        end

        sender_idle_pct = 0;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_tol)
            begin
                set_tolerance(directed_rows[i].tol);
            end
            else
            begin
                send_beat(directed_rows[i].beat, directed_rows[i].typed,
                          directed_rows[i].typed_res);
            end
        end

        // Random phases: back to back, heavy idling and light idling, across tolerances
        // from zero up to about twelve cells.
        run_random_phase(16, 0, 185);
        run_random_phase(40, 66, 185);
        run_random_phase(1, 19, 185);
        run_random_phase(0, 0, 185);
        run_random_phase(200, 66, 185);
        run_random_phase(90, 19, 185);

        wait_block_idle();

        $display("run covered %0d beats: %0d marks, %0d clears, %0d queries",
                 items_sent, marks_sent, clears_sent, queries_sent);
        $display("%0d results checked, %0d hits, tolerances 0 to 4095, idle rates 0 to 66",
                 results_checked, hits_seen);
        if (mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("%0d mismatches in total", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
